[rtl/ipp_message_byte_parser_defines.svh]
// Assertion macros used by the IPP message byte parser module.
`ifndef IPP_MESSAGE_BYTE_PARSER_DEFINES_SVH
`define IPP_MESSAGE_BYTE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ipp_pkg.sv]
// Types and constants for the IPP message byte parser.
package ipp_pkg;

  typedef enum logic [8:0] {
    PH_HDR  = 9'b000000001,
    PH_TAG  = 9'b000000010,
    PH_NLH  = 9'b000000100,
    PH_NLL  = 9'b000001000,
    PH_NAME = 9'b000010000,
    PH_VLH  = 9'b000100000,
    PH_VLL  = 9'b001000000,
    PH_VAL  = 9'b010000000,
    PH_DOC  = 9'b100000000
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_VERSION = 4'd0,
    ROLE_OPCODE  = 4'd1,
    ROLE_REQID   = 4'd2,
    ROLE_GROUP   = 4'd3,
    ROLE_VTAG    = 4'd4,
    ROLE_NLEN    = 4'd5,
    ROLE_NAME    = 4'd6,
    ROLE_VLEN    = 4'd7,
    ROLE_VALUE   = 4'd8,
    ROLE_END     = 4'd9,
    ROLE_DOC     = 4'd10,
    ROLE_IGNORED = 4'd11
  } role_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  localparam logic [7:0] TAG_END       = 8'h03;
  localparam logic [7:0] TAG_GRP_LO    = 8'h01;
  localparam logic [7:0] TAG_GRP_HI    = 8'h0F;
  localparam logic [3:0] TAG_OPERATION = 4'h1;
  localparam logic [2:0] HDR_LAST      = 3'd7;
  localparam logic [2:0] HDR_OP_HI     = 3'd1;
  localparam logic [2:0] HDR_ID_HI     = 3'd3;
  localparam logic [2:0] HDR_REQ_LO    = 3'd4;
  localparam logic [2:0] HDR_OP_LO     = 3'd2;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] bytes_left;
    logic [31:0] word_accum;
    logic [2:0]  header_count;
    logic [3:0]  group_reg;
    logic [7:0]  tag_reg;
    logic        inherit_flag;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:        PH_HDR,
    bytes_left:   16'd0,
    word_accum:   32'd0,
    header_count: 3'd0,
    group_reg:    4'd0,
    tag_reg:      8'd0,
    inherit_flag: 1'b0
  };

  typedef struct packed {
    role_t       role;
    logic [3:0]  group_now;
    logic [7:0]  attr_tag;
    logic        inherits_name;
    logic        field_done;
    logic [31:0] field_value;
    logic        attribute_done;
    logic [1:0]  parse_status;
  } res_t;

endpackage

[rtl/ipp_message_byte_parser.sv]
// A byte accepted into the input register has its result registered in the result register.
// Throughput: one byte per cycle while out_ready keeps up; the input register and the result register
// let a new byte enter while a finished result waits to be taken.
// Reset (rst, synchronous): clears both valid flags and returns the parser to the
// header phase with no group, no tag and empty accumulators.
// The parser also returns to that state by itself after each message's last byte.
`include "ipp_message_byte_parser_defines.svh"

module ipp_message_byte_parser import ipp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  byte_role,
  output logic [7:0]  out_byte,
  output logic [3:0]  group_now,
  output logic [7:0]  attr_tag,
  output logic        inherits_name,
  output logic        field_done,
  output logic [31:0] field_value,
  output logic        attribute_done,
  output logic        message_end,
  output logic [1:0]  parse_status
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       adv;
  state_t     st;
  state_t     st_next;
  res_t       res;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= is_last;
    end
  end

  ipp_step u_step (
    .st      (st),
    .in_byte (s1_byte),
    .is_last (s1_last),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_role      <= res.role;
      out_byte       <= s1_byte;
      group_now      <= res.group_now;
      attr_tag       <= res.attr_tag;
      inherits_name  <= res.inherits_name;
      field_done     <= res.field_done;
      field_value    <= res.field_value;
      attribute_done <= res.attribute_done;
      message_end    <= s1_last;
      parse_status   <= res.parse_status;
    end
  end

  `IPP_ASSERT_NOW(a_value_only_when_done, clk, rst, out_valid && !field_done, field_value == 32'd0, "field_value set without field_done")
  `IPP_ASSERT_NOW(a_status_only_at_end, clk, rst, out_valid && !message_end, parse_status == STAT_OK, "parse_status set before message end")
  `IPP_ASSERT_NOW(a_attr_done_role, clk, rst, out_valid && attribute_done, byte_role == ROLE_VLEN || byte_role == ROLE_VALUE, "attribute completed on a byte that is not a value length or value byte")
  `IPP_ASSERT_NEXT(a_reset_after_last, clk, rst, adv && s1_last, st.phase == PH_HDR && st.group_reg == 4'd0 && st.header_count == 3'd0, "parser state not cleared after the last byte")

endmodule

[rtl/ipp_step.sv]
// Next-state and result logic for one message byte.
module ipp_step import ipp_pkg::*; (
  input  state_t     st,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output state_t     st_next,
  output res_t       res
);

  state_t      nxt;
  logic [15:0] len16;
  logic [15:0] left_dec;
  logic [31:0] hdr_acc;

  assign len16    = {st.word_accum[7:0], in_byte};
  assign left_dec = st.bytes_left - 16'd1;
  assign hdr_acc  = {st.word_accum[23:0], in_byte};

  always_comb begin
    nxt                = st;
    res.role           = ROLE_IGNORED;
    res.inherits_name  = 1'b0;
    res.field_done     = 1'b0;
    res.field_value    = 32'd0;
    res.attribute_done = 1'b0;
    unique case (st.phase)
      PH_TAG: begin
        if (in_byte == TAG_END) begin
          res.role  = ROLE_END;
          nxt.phase = PH_DOC;
        end else if (in_byte >= TAG_GRP_LO && in_byte <= TAG_GRP_HI) begin
          res.role      = ROLE_GROUP;
          nxt.group_reg = in_byte[3:0];
        end else begin
          res.role = ROLE_VTAG;
          if (st.group_reg == 4'd0) begin
            nxt.group_reg = TAG_OPERATION;
          end
          nxt.tag_reg      = in_byte;
          nxt.inherit_flag = 1'b0;
          nxt.phase        = PH_NLH;
        end
      end
      PH_NLH: begin
        res.role       = ROLE_NLEN;
        nxt.word_accum = {24'd0, in_byte};
        nxt.phase      = PH_NLL;
      end
      PH_NLL: begin
        res.role        = ROLE_NLEN;
        nxt.word_accum  = {16'd0, len16};
        res.field_done  = 1'b1;
        res.field_value = {16'd0, len16};
        if (len16 == 16'd0) begin
          nxt.inherit_flag = 1'b1;
          nxt.phase        = PH_VLH;
        end else begin
          nxt.inherit_flag = 1'b0;
          nxt.bytes_left   = len16;
          nxt.phase        = PH_NAME;
        end
        res.inherits_name = (len16 == 16'd0);
      end
      PH_NAME: begin
        res.role       = ROLE_NAME;
        nxt.bytes_left = left_dec;
        if (left_dec == 16'd0) begin
          nxt.phase = PH_VLH;
        end
      end
      PH_VLH: begin
        res.role          = ROLE_VLEN;
        res.inherits_name = st.inherit_flag;
        nxt.word_accum    = {24'd0, in_byte};
        nxt.phase         = PH_VLL;
      end
      PH_VLL: begin
        res.role          = ROLE_VLEN;
        res.inherits_name = st.inherit_flag;
        nxt.word_accum    = {16'd0, len16};
        res.field_done    = 1'b1;
        res.field_value   = {16'd0, len16};
        if (len16 == 16'd0) begin
          res.attribute_done = 1'b1;
          nxt.phase          = PH_TAG;
        end else begin
          nxt.bytes_left = len16;
          nxt.phase      = PH_VAL;
        end
      end
      PH_VAL: begin
        res.role          = ROLE_VALUE;
        res.inherits_name = st.inherit_flag;
        nxt.bytes_left    = left_dec;
        if (left_dec == 16'd0) begin
          res.attribute_done = 1'b1;
          nxt.phase          = PH_TAG;
        end
      end
      PH_DOC: begin
        res.role = ROLE_DOC;
      end
      PH_HDR: begin
        if (st.header_count < HDR_OP_LO) begin
          res.role = ROLE_VERSION;
        end else if (st.header_count < HDR_REQ_LO) begin
          res.role = ROLE_OPCODE;
        end else begin
          res.role = ROLE_REQID;
        end
        nxt.word_accum = hdr_acc;
        if (st.header_count == HDR_OP_HI || st.header_count == HDR_ID_HI) begin
          res.field_done  = 1'b1;
          res.field_value = {16'd0, hdr_acc[15:0]};
        end else if (st.header_count == HDR_LAST) begin
          res.field_done  = 1'b1;
          res.field_value = hdr_acc;
        end
        if (st.header_count == HDR_LAST) begin
          nxt.header_count = 3'd0;
          nxt.word_accum   = 32'd0;
          nxt.phase        = PH_TAG;
        end else begin
          nxt.header_count = st.header_count + 3'd1;
        end
      end
      default: begin
        nxt = ST_RESET;
      end
    endcase

    res.group_now = nxt.group_reg;
    res.attr_tag  = nxt.tag_reg;
    if (!is_last) begin
      res.parse_status = STAT_OK;
    end else if (nxt.phase == PH_HDR) begin
      res.parse_status = STAT_SHORT;
    end else if (nxt.phase == PH_TAG || nxt.phase == PH_DOC) begin
      res.parse_status = STAT_OK;
    end else begin
      res.parse_status = STAT_TRUNC;
    end

    st_next = is_last ? ST_RESET : nxt;
  end

endmodule

[tb/ipp_message_byte_parser_checker.sv]
// Checker that predicts every result of the IPP message byte parser and compares it.
module ipp_message_byte_parser_checker import ipp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  byte_role,
  input  logic [7:0]  out_byte,
  input  logic [3:0]  group_now,
  input  logic [7:0]  attr_tag,
  input  logic        inherits_name,
  input  logic        field_done,
  input  logic [31:0] field_value,
  input  logic        attribute_done,
  input  logic        message_end,
  input  logic [1:0]  parse_status,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    role_t       role;
    logic [7:0]  data;
    logic [3:0]  grp;
    logic [7:0]  tag;
    logic        inh;
    logic        done;
    logic [31:0] value;
    logic        adone;
    logic        last;
    logic [1:0]  status;
  } byte_report_t;

  byte_report_t expected_reports [$];

  phase_t      ph;
  logic [15:0] remaining;
  logic [31:0] accum;
  logic [2:0]  hdr_idx;
  logic [3:0]  cur_group;
  logic [7:0]  cur_tag;
  logic        name_reused;
  int          errors = 0;

  assign fail_count = errors;

  function automatic void reset_parser();
    ph = PH_HDR;
    remaining = '0;
    accum = '0;
    hdr_idx = '0;
    cur_group = '0;
    cur_tag = '0;
    name_reused = 1'b0;
  endfunction

  function automatic byte_report_t parse_byte(input logic [7:0] b, input logic last);
    byte_report_t r;
    r = '0;
    r.role = ROLE_IGNORED;
    r.data = b;
    r.last = last;
    case (ph)
      PH_TAG: begin
        if (b == TAG_END) begin
          r.role = ROLE_END;
          ph = PH_DOC;
        end else if (b >= TAG_GRP_LO && b <= TAG_GRP_HI) begin
          r.role = ROLE_GROUP;
          cur_group = b[3:0];
        end else begin
          r.role = ROLE_VTAG;
          if (cur_group == 4'd0) cur_group = TAG_OPERATION;
          cur_tag = b;
          name_reused = 1'b0;
          ph = PH_NLH;
        end
      end
      PH_NLH: begin
        r.role = ROLE_NLEN;
        accum = {24'd0, b};
        ph = PH_NLL;
      end
      PH_NLL: begin
        r.role = ROLE_NLEN;
        accum = {16'd0, accum[7:0], b};
        r.done = 1'b1;
        r.value = accum;
        if (accum == 32'd0) begin
          name_reused = 1'b1;
          ph = PH_VLH;
        end else begin
          name_reused = 1'b0;
          remaining = accum[15:0];
          ph = PH_NAME;
        end
        r.inh = name_reused;
      end
      PH_NAME: begin
        r.role = ROLE_NAME;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = PH_VLH;
      end
      PH_VLH: begin
        r.role = ROLE_VLEN;
        r.inh = name_reused;
        accum = {24'd0, b};
        ph = PH_VLL;
      end
      PH_VLL: begin
        r.role = ROLE_VLEN;
        r.inh = name_reused;
        accum = {16'd0, accum[7:0], b};
        r.done = 1'b1;
        r.value = accum;
        if (accum == 32'd0) begin
          r.adone = 1'b1;
          ph = PH_TAG;
        end else begin
          remaining = accum[15:0];
          ph = PH_VAL;
        end
      end
      PH_VAL: begin
        r.role = ROLE_VALUE;
        r.inh = name_reused;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          r.adone = 1'b1;
          ph = PH_TAG;
        end
      end
      PH_DOC: r.role = ROLE_DOC;
      default: begin
        if (hdr_idx < HDR_OP_LO) r.role = ROLE_VERSION;
        else if (hdr_idx < HDR_REQ_LO) r.role = ROLE_OPCODE;
        else r.role = ROLE_REQID;
        accum = {accum[23:0], b};
        if (hdr_idx == HDR_OP_HI || hdr_idx == HDR_ID_HI) begin
          r.done = 1'b1;
          r.value = {16'd0, accum[15:0]};
        end else if (hdr_idx == HDR_LAST) begin
          r.done = 1'b1;
          r.value = accum;
        end
        if (hdr_idx == HDR_LAST) begin
          hdr_idx = '0;
          accum = '0;
          ph = PH_TAG;
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
    endcase

    if (last) begin
      if (ph == PH_HDR) r.status = STAT_SHORT;
      else if (ph == PH_TAG || ph == PH_DOC) r.status = STAT_OK;
      else r.status = STAT_TRUNC;
    end
    r.grp = cur_group;
    r.tag = cur_tag;
    if (last) reset_parser();
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    byte_report_t want;
    byte_report_t pred;
    if (rst) begin
      reset_parser();
      expected_reports.delete();
    end else begin
      if (in_valid && in_ready) begin
        pred = parse_byte(in_byte, is_last);
        expected_reports.insert(expected_reports.size(), pred);
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual role %0d byte %0h",
                   $time, byte_role, out_byte);
        end else begin
          want = expected_reports.pop_front();
          check_field("byte_role", 32'(want.role), 32'(byte_role));
          check_field("out_byte", 32'(want.data), 32'(out_byte));
          check_field("group_now", 32'(want.grp), 32'(group_now));
          check_field("attr_tag", 32'(want.tag), 32'(attr_tag));
          check_field("inherits_name", 32'(want.inh), 32'(inherits_name));
          check_field("field_done", 32'(want.done), 32'(field_done));
          check_field("field_value", want.value, field_value);
          check_field("attribute_done", 32'(want.adone), 32'(attribute_done));
          check_field("message_end", 32'(want.last), 32'(message_end));
          check_field("parse_status", 32'(want.status), 32'(parse_status));
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

[tb/tb_ipp_message_byte_parser.sv]
// Testbench top for the IPP message byte parser: clock, reset, stimulus and verdict.
module tb_ipp_message_byte_parser import ipp_pkg::*; ();

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 107;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  byte_role;
  logic [7:0]  out_byte;
  logic [3:0]  group_now;
  logic [7:0]  attr_tag;
  logic        inherits_name;
  logic        field_done;
  logic [31:0] field_value;
  logic        attribute_done;
  logic        message_end;
  logic [1:0]  parse_status;

  int fail_count;
  int outstanding;
  int cycle_n = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic [7:0] msg_bytes [$];

  ipp_message_byte_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_role(byte_role), .out_byte(out_byte), .group_now(group_now),
    .attr_tag(attr_tag), .inherits_name(inherits_name), .field_done(field_done),
    .field_value(field_value), .attribute_done(attribute_done),
    .message_end(message_end), .parse_status(parse_status)
  );

  ipp_message_byte_parser_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_role(byte_role), .out_byte(out_byte), .group_now(group_now),
    .attr_tag(attr_tag), .inherits_name(inherits_name), .field_done(field_done),
    .field_value(field_value), .attribute_done(attribute_done),
    .message_end(message_end), .parse_status(parse_status),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("ipp_message_byte_parser regression: fail");
      $finish;
    end
  end

  // The receiver owns out_ready; a hold request parks it low for a long stretch.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_group();
    logic [7:0] g;
    g = 8'($urandom_range(TAG_GRP_LO, TAG_GRP_HI - 1));
    if (g >= TAG_END) g = g + 8'd1;
    return g;
  endfunction

  function automatic logic [7:0] pick_value_tag();
    int r;
    r = $urandom_range(0, 240);
    return (r == 0) ? 8'd0 : 8'(r + 15);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 16);
    return $urandom_range(256, 300);
  endfunction

  task automatic append_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_queued();
    for (int i = 0; i < msg_bytes.size(); i++) send_item(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic push_field(input int n);
    int len;
    len = n;
    append_byte(len[15:8]);
    append_byte(len[7:0]);
    repeat (n) append_byte(rand_byte());
  endtask

  task automatic build_wellformed();
    msg_bytes.delete();
    repeat (8) append_byte(rand_byte());
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(99) < 40) append_byte(pick_group());
      append_byte(pick_value_tag());
      push_field(pick_len());
      push_field(pick_len());
    end
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(99) < 20) append_byte(pick_group());
      append_byte(TAG_END);
      repeat ($urandom_range(0, 3)) append_byte(rand_byte());
    end
  endtask

  task automatic send_message(input int budget);
    int kind;
    int keep;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_wellformed();
    end else if (kind < 85) begin
      build_wellformed();
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else begin
      msg_bytes.delete();
      repeat (kind < 93 ? $urandom_range(1, 7) : $urandom_range(1, 30))
        append_byte(rand_byte());
    end
    // The last message of a phase is cut so that each phase sends the same count.
    while (msg_bytes.size() > budget) void'(msg_bytes.pop_back());
    send_queued();
  endtask

  initial begin : stimulus
    int send_pcts [4];
    int stall_pcts [4];
    int phase_start;
    send_pcts = '{0, 47, 0, 37};
    stall_pcts = '{0, 0, 47, 37};
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'd0;
    is_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A one-byte message, then a full one: value tag with no group, a named
    // attribute, a group tag, an inherited name, the end tag and a document byte.
    msg_bytes = '{8'hFF};
    send_queued();
    msg_bytes = '{8'h02, 8'h00, 8'h00, 8'h0B, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'h47, 8'h00, 8'h01, 8'h61, 8'h00, 8'h00,
                  8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
                  TAG_END, 8'hAB};
    send_queued();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      if (p == 0) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE)
        send_message(ITEMS_PER_PHASE - (items_sent - phase_start));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ipp_message_byte_parser regression: pass");
    end else begin
      $display("ipp_message_byte_parser regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ipp_pkg.sv
rtl/ipp_step.sv
rtl/ipp_message_byte_parser.sv
tb/ipp_message_byte_parser_checker.sv
tb/tb_ipp_message_byte_parser.sv
